FILE: rtl/h264sb_pkg.sv
`default_nettype none

package h264sb_pkg;

  localparam int unsigned POOL_FRAMES = 24;

  // restoring steps: one quotient bit per cell
  localparam int unsigned ROW_STEPS = 16;
  localparam int unsigned DPB_STEPS = 4;
  localparam int unsigned QW        = 16;

  typedef struct packed {
    logic          zero_w;
    logic [8:0]    cols;
    logic [QW-1:0] rem;
    logic [QW-1:0] sr;
    logic [QW-1:0] quo;
    logic [QW-1:0] dvs;
    logic [4:0]    refs_lim;
    logic          compact;
    logic [19:0]   limit;
    logic [7:0]    rcrop;
    logic [7:0]    bcrop;
    logic [15:0]   rows;
    logic [15:0]   area;
    logic [25:0]   mvp;
    logic          sat;
    logic          dpb_off;
    logic [12:0]   vw;
    logic [19:0]   vh;
    logic [12:0]   cw;
    logic [19:0]   fh;
    logic          ovf;
    logic [4:0]    dpb;
    logic [4:0]    refc;
    logic [35:0]   mv;
  } pipe_t;

  // Table A-1 MaxDpbMbs, 0 for an unknown level
  function automatic logic [19:0] level_limit(input logic [7:0] lvl);
    logic [19:0] lim;
    case (lvl)
      8'd10:                lim = 20'd396;
      8'd11:                lim = 20'd900;
      8'd12, 8'd13, 8'd20:  lim = 20'd2376;
      8'd21:                lim = 20'd4752;
      8'd22, 8'd30:         lim = 20'd8100;
      8'd31:                lim = 20'd18000;
      8'd32:                lim = 20'd20480;
      8'd40, 8'd41:         lim = 20'd32768;
      8'd42:                lim = 20'd34816;
      8'd50:                lim = 20'd110400;
      8'd51, 8'd52:         lim = 20'd184320;
      8'd60, 8'd61, 8'd62:  lim = 20'd696320;
      default:              lim = 20'd0;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/h264sb_pipe_reg.sv
`default_nettype none

module h264sb_pipe_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  h264sb_pkg::pipe_t  data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output h264sb_pkg::pipe_t  data_o
);

  logic              valid_q;
  h264sb_pkg::pipe_t data_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/h264sb_div_cell.sv
`default_nettype none

module h264sb_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  h264sb_pkg::pipe_t  data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output h264sb_pkg::pipe_t  data_o
);

  logic                      valid_q;
  h264sb_pkg::pipe_t         data_q;
  h264sb_pkg::pipe_t         data_d;
  logic [h264sb_pkg::QW:0]   trial;
  logic                      fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {data_i.rem, data_i.sr[h264sb_pkg::QW-1]};
  assign fits  = trial >= {1'b0, data_i.dvs};

  always_comb begin
    data_d = data_i;
    if (fits) begin
      data_d.rem = h264sb_pkg::QW'(trial - {1'b0, data_i.dvs});
    end else begin
      data_d.rem = trial[h264sb_pkg::QW-1:0];
    end
    data_d.sr  = {data_i.sr[h264sb_pkg::QW-2:0], 1'b0};
    data_d.quo = {data_i.quo[h264sb_pkg::QW-2:0], fits};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/h264_stream_buffer_sizing.sv
// Pipeline stages: 16 row-divider cells, area multiply, DPB setup, 4 DPB-divider
//   cells, output stage.
// Throughput: one beat per cycle while the output is ready; a stalled output holds
//   the full stages behind it back to the first empty stage, which still fills.
// Reset clears the valid bit of every stage; the data registers are not reset.
`default_nettype none

module h264_stream_buffer_sizing (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  mb_columns_raw_i,
  input  logic [15:0] mb_total_i,
  input  logic [6:0]  ref_frames_hint_i,
  input  logic        compact_motion_i,
  input  logic [7:0]  level_code_i,
  input  logic [7:0]  right_crop_i,
  input  logic [7:0]  bottom_crop_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [4:0]  dpb_depth_o,
  output logic [4:0]  ref_count_o,
  output logic [35:0] mv_bytes_o,
  output logic [12:0] visible_width_o,
  output logic [19:0] visible_height_o,
  output logic [12:0] canvas_width_o,
  output logic [19:0] canvas_height_o,
  output logic        crop_overflow_o
);

  localparam int unsigned P1_IDX  = h264sb_pkg::ROW_STEPS;
  localparam int unsigned P2_IDX  = P1_IDX + 1;
  localparam int unsigned DPB_IDX = P2_IDX + 1;
  localparam int unsigned FIN_IDX = DPB_IDX + h264sb_pkg::DPB_STEPS;
  localparam int unsigned LAST    = FIN_IDX + 1;

  h264sb_pkg::pipe_t stage_d [0:LAST];
  logic              stage_v [0:LAST];
  logic              stage_r [0:LAST];

  h264sb_pkg::pipe_t p1_in;
  h264sb_pkg::pipe_t p2_in;
  h264sb_pkg::pipe_t fin_in;

  // ---- front: set up the row division
  logic [8:0] cols_in;
  logic       zero_in;

  assign zero_in = (mb_columns_raw_i == 8'd0) && (mb_total_i == 16'd0);
  assign cols_in = ((mb_columns_raw_i == 8'd0) && (mb_total_i != 16'd0)) ?
                   9'd256 : {1'b0, mb_columns_raw_i};

  always_comb begin
    stage_d[0]          = '0;
    stage_d[0].zero_w   = zero_in;
    stage_d[0].cols     = cols_in;
    stage_d[0].sr       = mb_total_i;
    stage_d[0].dvs      = {7'd0, cols_in};
    stage_d[0].compact  = compact_motion_i;
    stage_d[0].limit    = h264sb_pkg::level_limit(level_code_i);
    stage_d[0].rcrop    = right_crop_i;
    stage_d[0].bcrop    = bottom_crop_i;
    if (ref_frames_hint_i > 7'(h264sb_pkg::POOL_FRAMES - 1)) begin
      stage_d[0].refs_lim = 5'(h264sb_pkg::POOL_FRAMES - 1);
    end else begin
      stage_d[0].refs_lim = ref_frames_hint_i[4:0];
    end
  end

  assign stage_v[0]  = in_valid_i;
  assign in_ready_o  = stage_r[0];

  // ---- rows = total / cols
  for (genvar g = 0; g < h264sb_pkg::ROW_STEPS; g++) begin : g_row
    h264sb_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_v[g]),
      .ready_o (stage_r[g]),
      .data_i  (stage_d[g]),
      .valid_o (stage_v[g+1]),
      .ready_i (stage_r[g+1]),
      .data_o  (stage_d[g+1])
    );
  end

  // ---- area, frame and crop sizes
  logic [24:0] area_full;
  logic [12:0] fw;
  logic [19:0] fh;
  logic        ovf_w;
  logic        ovf_h;

  assign area_full = {16'd0, stage_d[P1_IDX].cols} * {9'd0, stage_d[P1_IDX].quo};
  assign fw        = {stage_d[P1_IDX].cols, 4'd0};
  assign fh        = {stage_d[P1_IDX].quo, 4'd0};
  assign ovf_w     = {5'd0, stage_d[P1_IDX].rcrop} > fw;
  assign ovf_h     = {12'd0, stage_d[P1_IDX].bcrop} > fh;

  always_comb begin
    p1_in      = stage_d[P1_IDX];
    p1_in.rows = stage_d[P1_IDX].quo;
    p1_in.area = area_full[15:0];
    p1_in.fh   = fh;
    p1_in.cw   = 13'(fw + 13'd31) & ~13'd31;
    p1_in.ovf  = ovf_w || ovf_h;
    p1_in.vw   = ovf_w ? 13'd0 : 13'(fw - {5'd0, stage_d[P1_IDX].rcrop});
    p1_in.vh   = ovf_h ? 20'd0 : 20'(fh - {12'd0, stage_d[P1_IDX].bcrop});
  end

  h264sb_pipe_reg u_p1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_v[P1_IDX]),
    .ready_o (stage_r[P1_IDX]),
    .data_i  (p1_in),
    .valid_o (stage_v[P2_IDX]),
    .ready_i (stage_r[P2_IDX]),
    .data_o  (stage_d[P2_IDX])
  );

  // ---- motion product and DPB division setup: ceil(limit/area), capped at 16
  logic [16:0] r4_rows;
  logic [8:0]  r4_cols;
  logic [20:0] dpb_num;

  assign r4_rows = 17'({1'b0, stage_d[P2_IDX].rows} + 17'd3) & ~17'd3;
  assign r4_cols = 9'(stage_d[P2_IDX].cols + 9'd3) & ~9'd3;
  assign dpb_num = 21'({1'b0, stage_d[P2_IDX].limit} + {5'd0, stage_d[P2_IDX].area}
                       - 21'd1);

  always_comb begin
    p2_in         = stage_d[P2_IDX];
    p2_in.mvp     = {9'd0, r4_rows} * {17'd0, r4_cols};
    p2_in.dpb_off = (stage_d[P2_IDX].limit == 20'd0) || (stage_d[P2_IDX].area == 16'd0);
    // below 16*area the top bits of the numerator already sit under the divisor
    p2_in.sat     = dpb_num >= {1'b0, stage_d[P2_IDX].area, 4'd0};
    p2_in.rem     = dpb_num[19:4];
    p2_in.sr      = {dpb_num[3:0], 12'd0};
    p2_in.quo     = '0;
    p2_in.dvs     = stage_d[P2_IDX].area;
  end

  h264sb_pipe_reg u_p2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_v[P2_IDX]),
    .ready_o (stage_r[P2_IDX]),
    .data_i  (p2_in),
    .valid_o (stage_v[DPB_IDX]),
    .ready_i (stage_r[DPB_IDX]),
    .data_o  (stage_d[DPB_IDX])
  );

  for (genvar g = 0; g < h264sb_pkg::DPB_STEPS; g++) begin : g_dpb
    h264sb_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_v[DPB_IDX+g]),
      .ready_o (stage_r[DPB_IDX+g]),
      .data_i  (stage_d[DPB_IDX+g]),
      .valid_o (stage_v[DPB_IDX+g+1]),
      .ready_i (stage_r[DPB_IDX+g+1]),
      .data_o  (stage_d[DPB_IDX+g+1])
    );
  end

  // ---- depth clamps and motion-vector bytes
  logic [5:0]  pool6;
  logic [5:0]  q6;
  logic [5:0]  dpb_lvl;
  logic [5:0]  dpb_fin;
  logic [5:0]  refs6;
  logic [6:0]  factor;
  logic [32:0] mv_base;
  logic [37:0] mv_sh;

  assign pool6   = 6'(h264sb_pkg::POOL_FRAMES);
  assign q6      = stage_d[FIN_IDX].sat ? 6'd16 : {2'd0, stage_d[FIN_IDX].quo[3:0]};
  assign dpb_lvl = stage_d[FIN_IDX].dpb_off ? pool6 : ((q6 > pool6) ? pool6 : q6);
  assign dpb_fin = ({1'b0, stage_d[FIN_IDX].refs_lim} > dpb_lvl) ?
                   {1'b0, stage_d[FIN_IDX].refs_lim} : dpb_lvl;
  assign refs6   = {1'b0, stage_d[FIN_IDX].refs_lim} + 6'd1;
  // 24 = 3 << 3, 96 = 3 << 5
  assign factor  = {refs6, 1'b0} + {1'b0, refs6};
  assign mv_base = {7'd0, stage_d[FIN_IDX].mvp} * {26'd0, factor};
  assign mv_sh   = stage_d[FIN_IDX].compact ? {2'd0, mv_base, 3'd0} : {mv_base, 5'd0};

  always_comb begin
    fin_in      = stage_d[FIN_IDX];
    fin_in.dpb  = dpb_fin[4:0];
    fin_in.refc = refs6[4:0];
    fin_in.mv   = mv_sh[35:0];
    if (stage_d[FIN_IDX].zero_w) begin
      fin_in.dpb  = '0;
      fin_in.refc = '0;
      fin_in.mv   = '0;
      fin_in.vw   = '0;
      fin_in.vh   = '0;
      fin_in.cw   = '0;
      fin_in.fh   = '0;
      fin_in.ovf  = 1'b0;
    end
  end

  h264sb_pipe_reg u_fin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_v[FIN_IDX]),
    .ready_o (stage_r[FIN_IDX]),
    .data_i  (fin_in),
    .valid_o (stage_v[LAST]),
    .ready_i (stage_r[LAST]),
    .data_o  (stage_d[LAST])
  );

  assign stage_r[LAST]    = out_ready_i;
  assign out_valid_o      = stage_v[LAST];
  assign status_o         = stage_d[LAST].zero_w;
  assign dpb_depth_o      = stage_d[LAST].dpb;
  assign ref_count_o      = stage_d[LAST].refc;
  assign mv_bytes_o       = stage_d[LAST].mv;
  assign visible_width_o  = stage_d[LAST].vw;
  assign visible_height_o = stage_d[LAST].vh;
  assign canvas_width_o   = stage_d[LAST].cw;
  assign canvas_height_o  = stage_d[LAST].fh;
  assign crop_overflow_o  = stage_d[LAST].ovf;

  // ---- checks
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output stage");

  a_zero_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> (dpb_depth_o == 5'd0) && (ref_count_o == 5'd0) &&
      (mv_bytes_o == 36'd0) && (canvas_height_o == 20'd0) && !crop_overflow_o)
    else $error("zero-width result carries nonzero fields");

  a_canvas_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (canvas_width_o >= visible_width_o) &&
      (canvas_height_o >= visible_height_o))
    else $error("visible size exceeds canvas");

  a_crop_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crop_overflow_o |-> (visible_width_o == 13'd0) ||
      (visible_height_o == 20'd0))
    else $error("crop overflow without a zero visible dimension");

endmodule

`default_nettype wire
